// ===== rtl/pfmr_pkg.sv =====
package pfmr_pkg;

    localparam int SIDE_DEFAULT = 64;
    localparam int BYTE_BITS    = 8;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_XFORM = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        OP_FLIP_ROWS = 2'd0,
        OP_FLIP_COLS = 2'd1,
        OP_ROT_CW    = 2'd2,
        OP_ROT_CCW   = 2'd3
    } xform_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_XFORM,
        ST_XDRAIN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/page_frame_mirror_rotate.sv =====
// Channel   Handshake              Payload
// request   req_valid / req_ready  req_type, page_index, column_index, write_byte, transform_op
// response  rsp_valid / rsp_ready  read_byte, done_kind
//
// One item at a time. Clear writes zero to every frame byte; a transform
// issues one frame read per destination bit through the single read port
// of the live frame bank.
// After reset a clearing pass zeros the frame; req_ready stays low until it
// ends. A response waits in an output register, so the next item is taken
// while rsp_ready is low; a finished item stalls only if that register is
// still full.
module page_frame_mirror_rotate
    import pfmr_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           req_type,
    input  logic [2:0]           page_index,
    input  logic [5:0]           column_index,
    input  logic [BYTE_BITS-1:0] write_byte,
    input  logic [1:0]           transform_op,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [BYTE_BITS-1:0] read_byte,
    output logic [1:0]           done_kind
);

    // frame geometry
    localparam int PAGES = SIDE / 8;
    localparam int STORE = SIDE * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(SIDE);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(SIDE - 1);
    localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES - 1);
    localparam logic [AW:0]   SIDE_W    = (AW + 1)'(SIDE);

    // Two banks: one holds the live frame, the other takes the transformed
    // frame. Swapping the bank select at the end of a transform stands in
    // for the copy back.
    state_t state_reg, state_next;
    logic   bank_sel_reg, bank_sel_next;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0] xp_reg, xp_next;
    logic [CW-1:0] xc_reg, xc_next;
    logic [2:0]    xb_reg, xb_next;

    // gather pipeline: one stage behind the read issue
    logic                 pv_reg, pv_next;
    logic [2:0]           pbit_reg;
    logic [2:0]           pb_reg;
    logic [AW-1:0]        pdst_reg;
    logic [BYTE_BITS-1:0] acc_reg, acc_next;

    req_type_t kind_reg;
    xform_op_t op_reg;
    logic      range_reg;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [BYTE_BITS-1:0] read_byte_reg;
    logic [1:0]           done_kind_reg;

    req_type_t     req_kind;
    logic          req_in_range;
    logic [AW-1:0] req_addr;
    logic          req_fire;
    logic          out_free;
    logic          clr_last;
    logic          x_last;
    logic [AW-1:0] src_addr;
    logic [2:0]    src_bit;
    logic [AW:0]   dst_w;
    logic [AW-1:0] dst_addr;

    logic                 act_we, ina_we, rd_en;
    logic [AW-1:0]        act_waddr, ina_waddr, raddr;
    logic [BYTE_BITS-1:0] act_wdata, ina_wdata;
    logic                 we_a, we_b;
    logic [AW-1:0]        waddr_a, waddr_b;
    logic [BYTE_BITS-1:0] wdata_a, wdata_b;
    logic [BYTE_BITS-1:0] rdata_a, rdata_b, rdata;
    logic                 pix;
    logic [BYTE_BITS-1:0] gathered;

    assign req_kind     = req_type_t'(req_type);
    assign req_in_range = (32'(page_index) < PAGES) && (32'(column_index) < SIDE);
    assign req_addr     = AW'(32'(page_index) * SIDE + 32'(column_index));
    assign req_ready    = (state_reg == ST_IDLE);
    assign req_fire     = req_valid && req_ready;
    assign out_free     = !rsp_valid_reg || rsp_ready;
    assign clr_last     = (clr_cnt_reg == LAST_ADDR);
    assign x_last       = (xp_reg == LAST_PAGE) && (xc_reg == LAST_COL) && (xb_reg == 3'd7);

    assign dst_w    = (AW + 1)'(xp_reg) * SIDE_W + (AW + 1)'(xc_reg);
    assign dst_addr = dst_w[AW-1:0];

    pfmr_src #(
        .SIDE (SIDE)
    ) u_src (
        .op       (op_reg),
        .page     (xp_reg),
        .col      (xc_reg),
        .bit_idx  (xb_reg),
        .src_addr (src_addr),
        .src_bit  (src_bit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_kind)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_XFORM: state_next = ST_XFORM;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_XFORM:
            begin
                if (x_last)
                begin
                    state_next = ST_XDRAIN;
                end
            end
            ST_XDRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pick the gathered pixel out of the returned source byte
    assign rdata    = bank_sel_reg ? rdata_b : rdata_a;
    assign pix      = rdata[pbit_reg];
    assign gathered = acc_reg | (BYTE_BITS'(pix) << pb_reg);

    // memory controls, counters and response
    always_comb
    begin
        act_we         = 1'b0;
        act_waddr      = clr_cnt_reg;
        act_wdata      = '0;
        ina_we         = 1'b0;
        ina_waddr      = pdst_reg;
        ina_wdata      = gathered;
        rd_en          = 1'b0;
        raddr          = src_addr;
        clr_cnt_next   = clr_cnt_reg;
        xp_next        = xp_reg;
        xc_next        = xc_reg;
        xb_next        = xb_reg;
        pv_next        = 1'b0;
        acc_next       = acc_reg;
        bank_sel_next  = bank_sel_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                act_we       = 1'b1;
                clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req_valid && req_in_range)
                begin
                    act_waddr = req_addr;
                    act_wdata = write_byte;
                    raddr     = req_addr;
                    act_we    = (req_kind == REQ_WRITE);
                    rd_en     = (req_kind == REQ_READ);
                end
            end
            ST_XFORM:
            begin
                rd_en   = 1'b1;
                pv_next = 1'b1;
                xb_next = xb_reg + 3'd1;
                if (xb_reg == 3'd7)
                begin
                    xc_next = (xc_reg == LAST_COL) ? '0 : xc_reg + 1'b1;
                    if (xc_reg == LAST_COL)
                    begin
                        xp_next = (xp_reg == LAST_PAGE) ? '0 : xp_reg + 1'b1;
                    end
                end
            end
            ST_XDRAIN:
            begin
                bank_sel_next = !bank_sel_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // finish a destination byte on its last gathered bit
        if (pv_reg)
        begin
            if (pb_reg == 3'd7)
            begin
                ina_we   = 1'b1;
                acc_next = '0;
            end
            else
            begin
                acc_next = gathered;
            end
        end
    end

    // route live-bank and spare-bank traffic to the physical banks
    always_comb
    begin
        if (bank_sel_reg)
        begin
            we_a    = ina_we;
            waddr_a = ina_waddr;
            wdata_a = ina_wdata;
            we_b    = act_we;
            waddr_b = act_waddr;
            wdata_b = act_wdata;
        end
        else
        begin
            we_a    = act_we;
            waddr_a = act_waddr;
            wdata_a = act_wdata;
            we_b    = ina_we;
            waddr_b = ina_waddr;
            wdata_b = ina_wdata;
        end
    end

    pfmr_ram #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata_a),
        .re    (rd_en && !bank_sel_reg),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    pfmr_ram #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata_b),
        .re    (rd_en && bank_sel_reg),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            bank_sel_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            xp_reg        <= '0;
            xc_reg        <= '0;
            xb_reg        <= '0;
            pv_reg        <= 1'b0;
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_sel_reg  <= bank_sel_next;
            clr_cnt_reg   <= clr_cnt_next;
            xp_reg        <= xp_next;
            xc_reg        <= xc_next;
            xb_reg        <= xb_next;
            pv_reg        <= pv_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg  <= req_kind;
            op_reg    <= xform_op_t'(transform_op);
            range_reg <= req_in_range;
        end
        if (state_reg == ST_XFORM)
        begin
            pbit_reg <= src_bit;
            pb_reg   <= xb_reg;
            pdst_reg <= dst_addr;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            read_byte_reg <= (kind_reg == REQ_READ && range_reg) ? rdata : '0;
            done_kind_reg <= kind_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_byte = read_byte_reg;
    assign done_kind = done_kind_reg;

`ifndef SYNTHESIS
    // the live bank swaps only as a transform drains
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_sel_reg != $past(bank_sel_reg)) |-> ($past(state_reg) == ST_XDRAIN))
        else $error("bank select changed outside transform drain");

    // only a read answers with a nonzero byte
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && done_kind != REQ_READ) |-> (read_byte == '0))
        else $error("nonzero read_byte on a non-read response");

    // an accepted item always starts work
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item left the block idle");

    // gather pipeline runs only behind transform reads
    a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> ($past(state_reg) == ST_XFORM))
        else $error("gather stage valid outside a transform");
`endif

endmodule

// ===== rtl/pfmr_ram.sv =====
module pfmr_ram
    import pfmr_pkg::*;
#(
    parameter int DEPTH = SIDE_DEFAULT * SIDE_DEFAULT / BYTE_BITS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [BYTE_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [BYTE_BITS-1:0] rdata
);

    logic [BYTE_BITS-1:0] mem [DEPTH];
    logic [BYTE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pfmr_src.sv =====
module pfmr_src
    import pfmr_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
)
(
    input  xform_op_t                       op,
    input  logic [((SIDE/8 > 1) ? $clog2(SIDE/8) : 1)-1:0] page,
    input  logic [$clog2(SIDE)-1:0]         col,
    input  logic [2:0]                      bit_idx,
    output logic [$clog2(SIDE*(SIDE/8))-1:0] src_addr,
    output logic [2:0]                      src_bit
);

    localparam int PAGES = SIDE / 8;
    localparam int STORE = SIDE * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(SIDE);
    localparam logic [CW-1:0] LAST_IDX = CW'(SIDE - 1);
    localparam logic [AW:0]   SIDE_W   = (AW + 1)'(SIDE);

    logic [CW-1:0] row;
    logic [CW-1:0] row_mir;
    logic [CW-1:0] col_mir;
    logic [CW-1:0] src_row;
    logic [CW-1:0] src_col;
    logic [AW:0]   addr_w;

    always_comb
    begin
        row     = CW'({page, bit_idx});
        row_mir = LAST_IDX - row;
        col_mir = LAST_IDX - col;
        case (op)
            OP_FLIP_ROWS:
            begin
                src_row = row_mir;
                src_col = col;
            end
            OP_FLIP_COLS:
            begin
                src_row = row;
                src_col = col_mir;
            end
            OP_ROT_CW:
            begin
                src_row = col_mir;
                src_col = row;
            end
            OP_ROT_CCW:
            begin
                src_row = col;
                src_col = row_mir;
            end
            default:
            begin
                src_row = row;
                src_col = col;
            end
        endcase
        // page of the source row times the page stride, plus the column
        addr_w   = (AW + 1)'(src_row >> 3) * SIDE_W + (AW + 1)'(src_col);
        src_addr = addr_w[AW-1:0];
        src_bit  = src_row[2:0];
    end

endmodule
